// ===== src/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg: shared constants and types for the deadline timer queue
// Slot geometry, action and cell mode codes, and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 31;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_EXPIRE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_POP    = 2'd3;

    typedef struct packed {
        logic [TIME_BITS-1:0] dl;
        logic [ID_BITS-1:0]   id;
    } slot_t;

    typedef struct packed {
        logic [1:0]         mode;
        slot_t              new_slot;
        logic [ID_BITS-1:0] cid;
    } cell_ctl_t;

endpackage

// ===== src/dtq_ifs.sv =====
// ----------------------------------------------------------------------------
// dtq_ifs: request and response channels of the deadline timer queue
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtq_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [dtq_pkg::TIME_BITS-1:0] now_ms;
    logic [dtq_pkg::ID_BITS-1:0]   delay_ms;
    logic [dtq_pkg::ID_BITS-1:0]   cancel_id;

    modport source (output valid, action, now_ms, delay_ms, cancel_id, input ready);
    modport sink   (input valid, action, now_ms, delay_ms, cancel_id, output ready);
endinterface

interface dtq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dtq_pkg::ID_BITS-1:0]   timer_id;
    logic                          status;
    logic                          found;
    logic                          is_expiry;
    logic [dtq_pkg::TIME_BITS-1:0] remaining_ms;
    logic                          last;

    modport source (output valid, timer_id, status, found, is_expiry, remaining_ms, last,
                    input ready);
    modport sink   (input valid, timer_id, status, found, is_expiry, remaining_ms, last,
                    output ready);
endinterface

// ===== src/dtq_cell.sv =====
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted timer chain
// Holds a deadline and id; inserts, shifts right, or shifts left on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_cell (
    input  logic               clk,
    input  dtq_pkg::cell_ctl_t ctl,
    input  logic               occ,
    input  dtq_pkg::slot_t     left,
    input  dtq_pkg::slot_t     right,
    input  logic               prev_ahead,
    input  logic               prev_seen,
    output dtq_pkg::slot_t     slot,
    output logic               ahead,
    output logic               seen
);

    dtq_pkg::slot_t slot_reg;
    dtq_pkg::slot_t slot_next;

    assign slot  = slot_reg;
    assign ahead = occ && (slot_reg.dl <= ctl.new_slot.dl);
    assign seen  = prev_seen || (occ && (slot_reg.id == ctl.cid));

    always_comb
    begin
        slot_next = slot_reg;
        case (ctl.mode)
            dtq_pkg::MODE_INSERT:
            begin
                if (!ahead)
                begin
                    slot_next = prev_ahead ? ctl.new_slot : left;
                end
            end
            dtq_pkg::MODE_CANCEL:
            begin
                if (seen)
                begin
                    slot_next = right;
                end
            end
            dtq_pkg::MODE_POP:
            begin
                slot_next = right;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== src/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue: bounded deadline-ordered table of one-shot timers
// Set and cancel are accepted in IDLE; EXEC then updates the cell chain and loads
// the response register. Expire pops one due timer per cycle while the response
// register is free, then loads a final response; response back-pressure stalls it.
// Reset (rst_n, async) empties the table and restarts ids at 1; ready at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue (
    input  logic          clk,
    input  logic          rst_n,
    dtq_req_if.sink       req,
    dtq_rsp_if.source     rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_EXPIRE = 2'd2;

    localparam logic [dtq_pkg::ID_BITS-1:0] ID_MAX = '1;
    localparam logic [dtq_pkg::ID_BITS-1:0] ID_ONE = dtq_pkg::ID_BITS'(1);
    localparam logic [dtq_pkg::CNT_BITS-1:0] CNT_FULL = dtq_pkg::CNT_BITS'(dtq_pkg::DEPTH);

    logic [1:0]                       state_reg, state_next;
    logic [1:0]                       act_reg, act_next;
    logic [dtq_pkg::TIME_BITS-1:0]    now_reg, now_next;
    logic [dtq_pkg::TIME_BITS-1:0]    dl_reg, dl_next;
    logic [dtq_pkg::ID_BITS-1:0]      cid_reg, cid_next;
    logic [dtq_pkg::CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [dtq_pkg::ID_BITS-1:0]      id_reg, id_next;

    logic                             out_valid_reg, out_valid_next;
    logic [dtq_pkg::ID_BITS-1:0]      out_id_reg, out_id_next;
    logic                             out_status_reg, out_status_next;
    logic                             out_found_reg, out_found_next;
    logic                             out_exp_reg, out_exp_next;
    logic [dtq_pkg::TIME_BITS-1:0]    out_rem_reg, out_rem_next;
    logic                             out_last_reg, out_last_next;

    logic [dtq_pkg::TIME_BITS:0]      sum;
    logic                             req_acc;
    logic                             out_free;
    logic                             out_load;
    logic                             head_due;
    logic [1:0]                       cell_mode;

    dtq_pkg::cell_ctl_t               ctl;
    dtq_pkg::slot_t                   slots [dtq_pkg::DEPTH];
    logic [dtq_pkg::DEPTH-1:0]        occ;
    logic [dtq_pkg::DEPTH:0]          ahead_chain;
    logic [dtq_pkg::DEPTH:0]          seen_chain;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign sum = {1'b0, req.now_ms}
               + {{(dtq_pkg::TIME_BITS + 1 - dtq_pkg::ID_BITS){1'b0}}, req.delay_ms};

    assign head_due = occ[0] && (slots[0].dl <= now_reg);

    // cell chain
    assign ahead_chain[0] = 1'b1;
    assign seen_chain[0]  = 1'b0;

    assign ctl.mode        = cell_mode;
    assign ctl.new_slot.dl = dl_reg;
    assign ctl.new_slot.id = id_reg;
    assign ctl.cid         = cid_reg;

    genvar gi;
    generate
        for (gi = 0; gi < dtq_pkg::DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = (cnt_reg > dtq_pkg::CNT_BITS'(gi));
            dtq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occ        (occ[gi]),
                .left       ((gi == 0) ? ctl.new_slot : slots[(gi == 0) ? 0 : gi - 1]),
                .right      (slots[(gi == dtq_pkg::DEPTH - 1) ? gi : gi + 1]),
                .prev_ahead (ahead_chain[gi]),
                .prev_seen  (seen_chain[gi]),
                .slot       (slots[gi]),
                .ahead      (ahead_chain[gi + 1]),
                .seen       (seen_chain[gi + 1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        now_next        = now_reg;
        dl_next         = dl_reg;
        cid_next        = cid_reg;
        cnt_next        = cnt_reg;
        id_next         = id_reg;
        cell_mode       = dtq_pkg::MODE_HOLD;
        out_load        = 1'b0;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_exp_next    = out_exp_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.action != dtq_pkg::ACT_NONE))
                begin
                    act_next   = req.action;
                    now_next   = req.now_ms;
                    cid_next   = req.cancel_id;
                    dl_next    = sum[dtq_pkg::TIME_BITS] ? '1 : sum[dtq_pkg::TIME_BITS-1:0];
                    state_next = (req.action == dtq_pkg::ACT_EXPIRE) ? ST_EXPIRE : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_id_next     = '0;
                    out_status_next = 1'b0;
                    out_found_next  = 1'b0;
                    out_exp_next    = 1'b0;
                    out_rem_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    if (act_reg == dtq_pkg::ACT_SET)
                    begin
                        if (cnt_reg == CNT_FULL)
                        begin
                            out_status_next = 1'b1;
                        end
                        else
                        begin
                            cell_mode   = dtq_pkg::MODE_INSERT;
                            out_id_next = id_reg;
                            cnt_next    = cnt_reg + 1'b1;
                            id_next     = (id_reg == ID_MAX) ? ID_ONE : id_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cell_mode      = dtq_pkg::MODE_CANCEL;
                        out_found_next = seen_chain[dtq_pkg::DEPTH];
                        if (seen_chain[dtq_pkg::DEPTH])
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
            end
            ST_EXPIRE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = 1'b0;
                    out_found_next  = 1'b0;
                    if (head_due)
                    begin
                        cell_mode     = dtq_pkg::MODE_POP;
                        out_id_next   = slots[0].id;
                        out_exp_next  = 1'b1;
                        out_rem_next  = '0;
                        out_last_next = 1'b0;
                        cnt_next      = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        out_id_next   = '0;
                        out_exp_next  = 1'b0;
                        out_rem_next  = occ[0] ? (slots[0].dl - now_reg) : '0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            id_reg        <= ID_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        now_reg        <= now_next;
        dl_reg         <= dl_next;
        cid_reg        <= cid_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_exp_reg    <= out_exp_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.timer_id     = out_id_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.is_expiry    = out_exp_reg;
    assign rsp.remaining_ms = out_rem_reg;
    assign rsp.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond table depth");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        id_reg != '0)
        else $error("id counter reached zero");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ[1] |-> (slots[0].dl <= slots[1].dl))
        else $error("chain head out of deadline order");

    a_expiry_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_exp_next) |-> (state_reg == ST_EXPIRE) && head_due)
        else $error("expiry response outside expire pass");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.action == dtq_pkg::ACT_SET || req.action == dtq_pkg::ACT_CANCEL))
        |=> (state_reg == ST_EXEC))
        else $error("set or cancel request not executed");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the deadline timer queue
// Runs directed sequences (empty table, deadline ties, cancel hits and misses,
// ignored actions, saturating deadlines, a full table drained in one expire)
// and then random set/cancel/expire traffic. A behavioral copy of the timer
// table predicts every response, which is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [dtq_pkg::TIME_BITS-1:0] TIME_MAX    = '1;
    localparam logic [dtq_pkg::ID_BITS-1:0]   ID_MAX      = '1;
    localparam int                            CYCLE_LIMIT = 1000000;
    localparam int                            RANDOM_REQS = 70;

    typedef struct packed {
        logic [dtq_pkg::ID_BITS-1:0]   timer_id;
        logic                          status;
        logic                          found;
        logic                          is_expiry;
        logic [dtq_pkg::TIME_BITS-1:0] remaining_ms;
        logic                          last;
    } timer_answer_t;

    logic clk;
    logic rst_n;

    dtq_req_if req_ch ();
    dtq_rsp_if rsp_ch ();

    deadline_timer_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [dtq_pkg::TIME_BITS-1:0] slot_dl [dtq_pkg::DEPTH];
    logic [dtq_pkg::ID_BITS-1:0]   slot_id [dtq_pkg::DEPTH];
    int                            live_count;
    logic [dtq_pkg::ID_BITS-1:0]   id_counter;

    timer_answer_t timer_answers [$];

    int mismatches;
    int cycle_count;
    int stall_left;
    bit req_gaps_on;
    bit rsp_stalls_on;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void add_answer(logic [dtq_pkg::ID_BITS-1:0] id, logic st, logic fnd,
                                       logic exp_flag, logic [dtq_pkg::TIME_BITS-1:0] rem,
                                       logic lst);
        timer_answer_t a;
        a.timer_id     = id;
        a.status       = st;
        a.found        = fnd;
        a.is_expiry    = exp_flag;
        a.remaining_ms = rem;
        a.last         = lst;
        timer_answers.push_back(a);
    endfunction

    function automatic void drop_slot(int pos);
        int i;
        for (i = pos; i < live_count - 1; i++)
        begin
            slot_dl[i] = slot_dl[i + 1];
            slot_id[i] = slot_id[i + 1];
        end
        live_count--;
    endfunction

    function automatic void run_timer_request(logic [1:0] act,
                                              logic [dtq_pkg::TIME_BITS-1:0] now,
                                              logic [dtq_pkg::ID_BITS-1:0] delay,
                                              logic [dtq_pkg::ID_BITS-1:0] cid);
        logic [dtq_pkg::TIME_BITS:0]   sum;
        logic [dtq_pkg::TIME_BITS-1:0] dl;
        int                            pos;
        int                            i;
        bit                            hit;
        case (act)
            dtq_pkg::ACT_SET:
            begin
                if (live_count >= dtq_pkg::DEPTH)
                begin
                    add_answer('0, 1'b1, 1'b0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    sum = {1'b0, now}
                        + {{(dtq_pkg::TIME_BITS + 1 - dtq_pkg::ID_BITS){1'b0}}, delay};
                    dl  = sum[dtq_pkg::TIME_BITS] ? TIME_MAX : sum[dtq_pkg::TIME_BITS-1:0];
                    pos = 0;
                    while (pos < live_count && slot_dl[pos] <= dl)
                        pos++;
                    for (i = live_count; i > pos; i--)
                    begin
                        slot_dl[i] = slot_dl[i - 1];
                        slot_id[i] = slot_id[i - 1];
                    end
                    slot_dl[pos] = dl;
                    slot_id[pos] = id_counter;
                    live_count++;
                    add_answer(id_counter, 1'b0, 1'b0, 1'b0, '0, 1'b1);
                    id_counter = (id_counter == ID_MAX) ? dtq_pkg::ID_BITS'(1)
                                                        : id_counter + 1'b1;
                end
            end
            dtq_pkg::ACT_CANCEL:
            begin
                hit = 1'b0;
                for (i = 0; i < live_count && !hit; i++)
                begin
                    if (slot_id[i] == cid)
                    begin
                        drop_slot(i);
                        hit = 1'b1;
                    end
                end
                add_answer('0, 1'b0, hit, 1'b0, '0, 1'b1);
            end
            dtq_pkg::ACT_EXPIRE:
            begin
                while (live_count > 0 && slot_dl[0] <= now)
                begin
                    add_answer(slot_id[0], 1'b0, 1'b0, 1'b1, '0, 1'b0);
                    drop_slot(0);
                end
                add_answer('0, 1'b0, 1'b0, 1'b0, (live_count > 0) ? slot_dl[0] - now : '0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] act,
                                input logic [dtq_pkg::TIME_BITS-1:0] now,
                                input logic [dtq_pkg::ID_BITS-1:0] delay,
                                input logic [dtq_pkg::ID_BITS-1:0] cid);
        int gap;
        gap = req_gaps_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.now_ms    <= now;
        req_ch.delay_ms  <= delay;
        req_ch.cancel_id <= cid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        run_timer_request(act, now, delay, cid);
    endtask

    task automatic hold_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (timer_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string field, logic [63:0] actual, logic [63:0] want);
        if (actual !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, actual);
            mismatches++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (!rsp_stalls_on)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        timer_answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (timer_answers.size() == 0)
            begin
                $error("response with no request outstanding: timer_id %0d", rsp_ch.timer_id);
                mismatches++;
            end
            else
            begin
                want = timer_answers.pop_front();
                compare_field("timer_id", 64'(rsp_ch.timer_id), 64'(want.timer_id));
                compare_field("status", 64'(rsp_ch.status), 64'(want.status));
                compare_field("found", 64'(rsp_ch.found), 64'(want.found));
                compare_field("is_expiry", 64'(rsp_ch.is_expiry), 64'(want.is_expiry));
                compare_field("remaining_ms", 64'(rsp_ch.remaining_ms),
                              64'(want.remaining_ms));
                compare_field("last", 64'(rsp_ch.last), 64'(want.last));
            end
        end
    end

    task automatic test_set_and_cancel();
        send_request(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        send_request(dtq_pkg::ACT_SET, 100, 0, '0);
        send_request(dtq_pkg::ACT_SET, 100, 50, '0);
        send_request(dtq_pkg::ACT_SET, 100, 50, ID_MAX);
        send_request(dtq_pkg::ACT_CANCEL, TIME_MAX, ID_MAX, 2);
        send_request(dtq_pkg::ACT_CANCEL, '0, '0, 2);
        send_request(dtq_pkg::ACT_CANCEL, '0, '0, '0);
        send_request(dtq_pkg::ACT_CANCEL, '0, '0, ID_MAX);
    endtask

    task automatic test_unknown_action();
        send_request(dtq_pkg::ACT_NONE, TIME_MAX, ID_MAX, ID_MAX);
        send_request(dtq_pkg::ACT_NONE, '0, '0, 1);
    endtask

    task automatic test_expire_order();
        send_request(dtq_pkg::ACT_EXPIRE, 99, '0, '0);
        send_request(dtq_pkg::ACT_EXPIRE, 150, ID_MAX, ID_MAX);
    endtask

    task automatic test_full_table_and_saturation();
        send_request(dtq_pkg::ACT_SET, TIME_MAX, ID_MAX, '0);
        send_request(dtq_pkg::ACT_SET, '0, ID_MAX, '0);
        send_request(dtq_pkg::ACT_SET, TIME_MAX - 5, 3, '0);
        send_request(dtq_pkg::ACT_SET, TIME_MAX - 5, 5, '0);
        repeat (dtq_pkg::DEPTH - 4)
            send_request(dtq_pkg::ACT_SET, 1000, dtq_pkg::ID_BITS'($urandom_range(0, 40)), '0);
        send_request(dtq_pkg::ACT_SET, 1000, 7, '0);
        send_request(dtq_pkg::ACT_EXPIRE, TIME_MAX, '0, '0);
    endtask

    task automatic test_random_traffic();
        logic [dtq_pkg::TIME_BITS-1:0] clock_ms;
        logic [dtq_pkg::ID_BITS-1:0]   cid;
        int                            r;
        int                            sent;
        clock_ms = dtq_pkg::TIME_BITS'($urandom);
        sent     = 0;
        while (sent < RANDOM_REQS)
        begin
            req_gaps_on   = (sent / 25) != 2;
            rsp_stalls_on = (sent / 25) != 1;
            if (sent == RANDOM_REQS / 2)
                hold_requests();
            r = $urandom_range(0, 99);
            if (r < 38)
            begin
                send_request(dtq_pkg::ACT_SET, clock_ms,
                             dtq_pkg::ID_BITS'($urandom_range(0, 200)),
                             dtq_pkg::ID_BITS'($urandom));
                sent++;
            end
            else if (r < 58)
            begin
                if (live_count > 0 && $urandom_range(0, 3) != 0)
                    cid = slot_id[$urandom_range(0, live_count - 1)];
                else
                    cid = dtq_pkg::ID_BITS'($urandom_range(0, id_counter));
                send_request(dtq_pkg::ACT_CANCEL, dtq_pkg::TIME_BITS'({$urandom, $urandom}),
                             dtq_pkg::ID_BITS'($urandom), cid);
                sent++;
            end
            else if (r < 88)
            begin
                clock_ms = clock_ms + $urandom_range(0, 150);
                send_request(dtq_pkg::ACT_EXPIRE, clock_ms, dtq_pkg::ID_BITS'($urandom),
                             dtq_pkg::ID_BITS'($urandom));
                sent++;
            end
            else if (r < 96)
            begin
                send_request(2'($urandom_range(0, 2)), dtq_pkg::TIME_BITS'({$urandom, $urandom}),
                             dtq_pkg::ID_BITS'($urandom), dtq_pkg::ID_BITS'($urandom));
                sent++;
            end
            else
            begin
                send_request(dtq_pkg::ACT_NONE, dtq_pkg::TIME_BITS'({$urandom, $urandom}),
                             dtq_pkg::ID_BITS'($urandom), dtq_pkg::ID_BITS'($urandom));
            end
        end
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        send_request(dtq_pkg::ACT_EXPIRE, TIME_MAX, '0, '0);
    endtask

    initial
    begin
        live_count       = 0;
        id_counter       = dtq_pkg::ID_BITS'(1);
        mismatches       = 0;
        cycle_count      = 0;
        stall_left       = 0;
        req_gaps_on      = 1'b0;
        rsp_stalls_on    = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = dtq_pkg::ACT_NONE;
        req_ch.now_ms    = '0;
        req_ch.delay_ms  = '0;
        req_ch.cancel_id = '0;
        rsp_ch.ready     = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_set_and_cancel();
        test_unknown_action();
        test_expire_order();
        test_full_table_and_saturation();
        hold_requests();
        test_random_traffic();

        hold_requests();
        repeat (dtq_pkg::DEPTH + 8)
            @(posedge clk);
        if (mismatches == 0 && timer_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
